### rtl/sbhs_pkg.sv
// Package: shared types, constants and codes for the sorted bucket hash set.
`default_nettype none
package sbhs_pkg;
    localparam int BUCKETS = 16384;
    localparam int SLOTS = 8;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int ADDR_W = BUCKET_W + SLOT_W;
    localparam int DEPTH = BUCKETS * SLOTS;
    localparam logic [31:0] BUCKET_LAST = 32'(BUCKETS - 1);

    // length / (BUCKETS-1) as a multiply by a rounded-up reciprocal and a shift;
    // exact for every 32-bit length
    localparam int DIV_SHIFT = 32 + $clog2(BUCKETS - 1);
    localparam logic [63:0] DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(BUCKETS - 2)) / 64'(BUCKETS - 1);

    localparam logic [2:0] ST_FOUND = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_DUP = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef struct packed {
        logic action;
        logic [31:0] key;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [31:0] found_value;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_HASH, S_FILLRD, S_FILLWAIT,
        S_SCANRD, S_SCANCHK, S_SHIFTRD, S_SHIFTWR, S_PLACE, S_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic div1_start;
        logic div2_start;
        logic hash;
        logic fill_cap;
        logic scan_rd;
        logic scan_chk;
        logic shift_rd;
        logic shift_wr;
        logic place;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_busy;
        logic dir;
        logic scan_end;
        logic hit;
        logic larger;
        logic shift_done;
        logic full;
        logic is_insert;
    } sts_t;
endpackage
`default_nettype wire

### rtl/sorted_bucket_hash_set.sv
// Top level: keyed set with range-partition hash and sorted bounded buckets.
// Each item is hashed by direct index or, when the length is BUCKETS or more, by a
// serial division of the key; its bucket is then scanned slot by slot, and an insert
// shifts the larger slots up and places the key. One item at a time: the next is
// taken once the result is loaded. After reset the bucket fill memory is cleared
// before the first item is taken; configuration writes are taken throughout.
`default_nettype none
module sorted_bucket_hash_set (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sbhs_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sbhs_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_data
);
    sbhs_pkg::cmd_t cmd;
    sbhs_pkg::sts_t sts;

    sbhs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
    );

    sbhs_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_item(in_data), .cmd(cmd), .sts(sts), .out_item(out_data)
    );
endmodule
`default_nettype wire

### rtl/sbhs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module sbhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/sbhs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module sbhs_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic      [31:0] quotient
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        trial = {r_reg, q_reg[31]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[32])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign quotient = q_reg;
endmodule
`default_nettype wire

### rtl/sbhs_ctrl.sv
// Controller state machine for the hash set.
`default_nettype none
module sbhs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire sbhs_pkg::sts_t sts,
    output sbhs_pkg::cmd_t      cmd
);
    sbhs_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbhs_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            sbhs_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = sbhs_pkg::S_IDLE;
                end
            end
            sbhs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = sbhs_pkg::S_DIV1;
                end
            end
            sbhs_pkg::S_DIV1:
            begin
                if (sts.dir)
                begin
                    state_next = sbhs_pkg::S_HASH;
                end
                else
                begin
                    cmd.div1_start = 1'b1;
                    state_next = sbhs_pkg::S_DIV2;
                end
            end
            sbhs_pkg::S_DIV2:
            begin
                if (!sts.div_busy)
                begin
                    cmd.div2_start = 1'b1;
                    state_next = sbhs_pkg::S_HASH;
                end
            end
            sbhs_pkg::S_HASH:
            begin
                if (!sts.div_busy)
                begin
                    cmd.hash = 1'b1;
                    state_next = sbhs_pkg::S_FILLRD;
                end
            end
            sbhs_pkg::S_FILLRD:
            begin
                state_next = sbhs_pkg::S_FILLWAIT;
            end
            sbhs_pkg::S_FILLWAIT:
            begin
                cmd.fill_cap = 1'b1;
                state_next = sbhs_pkg::S_SCANRD;
            end
            sbhs_pkg::S_SCANRD:
            begin
                if (sts.scan_end)
                begin
                    if (!sts.is_insert || sts.full)
                    begin
                        state_next = sbhs_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = sbhs_pkg::S_SHIFTRD;
                    end
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next = sbhs_pkg::S_SCANCHK;
                end
            end
            sbhs_pkg::S_SCANCHK:
            begin
                cmd.scan_chk = 1'b1;
                if (sts.hit || (sts.larger && !sts.is_insert))
                begin
                    state_next = sbhs_pkg::S_DONE;
                end
                else if (sts.larger)
                begin
                    state_next = sts.full ? sbhs_pkg::S_DONE : sbhs_pkg::S_SHIFTRD;
                end
                else
                begin
                    state_next = sbhs_pkg::S_SCANRD;
                end
            end
            sbhs_pkg::S_SHIFTRD:
            begin
                if (sts.shift_done)
                begin
                    state_next = sbhs_pkg::S_PLACE;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next = sbhs_pkg::S_SHIFTWR;
                end
            end
            sbhs_pkg::S_SHIFTWR:
            begin
                cmd.shift_wr = 1'b1;
                state_next = sbhs_pkg::S_SHIFTRD;
            end
            sbhs_pkg::S_PLACE:
            begin
                cmd.place = 1'b1;
                state_next = sbhs_pkg::S_DONE;
            end
            sbhs_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = sbhs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sbhs_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == sbhs_pkg::S_IDLE))
        else $error("ready outside idle");
    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result not presented");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("result overwritten");
    a_shift_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_rd |=> cmd.shift_wr)
        else $error("shift read without write");
`endif
endmodule
`default_nettype wire

### rtl/sbhs_dp.sv
// Datapath: hash, fill memory, key/value stores, scan and shift.
`default_nettype none
module sbhs_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_data,
    input  wire sbhs_pkg::in_item_t in_item,
    input  wire sbhs_pkg::cmd_t     cmd,
    output sbhs_pkg::sts_t          sts,
    output sbhs_pkg::out_item_t     out_item
);
    localparam int BW = sbhs_pkg::BUCKET_W;
    localparam int SW = sbhs_pkg::SLOT_W;
    localparam int FW = sbhs_pkg::FILL_W;
    localparam int AW = sbhs_pkg::ADDR_W;

    logic [31:0] tlen_reg;
    sbhs_pkg::in_item_t item_reg;
    logic [BW-1:0] bkt_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] idx_reg;
    logic [FW-1:0] pos_reg;
    logic [2:0] stat_reg;
    logic [31:0] fv_reg;
    logic [BW:0] clr_reg;
    logic [31:0] divisor_reg;
    sbhs_pkg::out_item_t out_reg;

    logic [64:0] tlen_prod;
    logic div_start;
    logic [31:0] div_a, div_b, div_q;
    logic div_busy;
    logic [31:0] idx32;

    logic fill_we;
    logic [BW-1:0] fill_addr;
    logic [FW-1:0] fill_wd, fill_rd;
    logic st_we;
    logic [AW-1:0] st_addr;
    logic [31:0] key_wd, key_rd, val_wd, val_rd;
    logic [FW-1:0] slot;

    // divisor = length / (BUCKETS-1) by reciprocal multiply
    assign tlen_prod = 65'(tlen_reg) * 65'(sbhs_pkg::DIV_RECIP);

    assign div_start = cmd.div2_start;
    assign div_a = item_reg.key;
    assign div_b = divisor_reg;

    sbhs_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .busy(div_busy), .quotient(div_q)
    );

    assign sts.dir = (tlen_reg < 32'(sbhs_pkg::BUCKETS));
    assign idx32 = sts.dir ? item_reg.key : div_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_reg <= 32'd1;
            clr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tlen_reg <= cfg_data;
            end
            if (cmd.clr_step && !clr_reg[BW])
            begin
                clr_reg <= clr_reg + (BW + 1)'(1);
            end
        end
    end

    // Shift moves slot idx-1 to slot idx, walking down from the fill.
    always_comb
    begin
        slot = idx_reg;
        if (cmd.shift_rd)
        begin
            slot = idx_reg - FW'(1);
        end
        else if (cmd.place)
        begin
            slot = pos_reg;
        end
    end

    assign st_addr = {bkt_reg, slot[SW-1:0]};
    assign st_we = cmd.shift_wr | cmd.place;
    assign key_wd = cmd.place ? item_reg.key : key_rd;
    assign val_wd = cmd.place ? item_reg.value : val_rd;

    assign fill_we = (cmd.clr_step && !clr_reg[BW]) || cmd.place;
    assign fill_addr = cmd.clr_step ? clr_reg[BW-1:0] : bkt_reg;
    assign fill_wd = cmd.clr_step ? '0 : fill_reg + FW'(1);

    sbhs_ram #(.WIDTH(FW), .DEPTH(sbhs_pkg::BUCKETS)) u_fill (
        .clk(clk), .we(fill_we), .addr(fill_addr), .wdata(fill_wd), .rdata(fill_rd)
    );
    sbhs_ram #(.WIDTH(32), .DEPTH(sbhs_pkg::DEPTH)) u_key (
        .clk(clk), .we(st_we), .addr(st_addr), .wdata(key_wd), .rdata(key_rd)
    );
    sbhs_ram #(.WIDTH(32), .DEPTH(sbhs_pkg::DEPTH)) u_val (
        .clk(clk), .we(st_we), .addr(st_addr), .wdata(val_wd), .rdata(val_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.div1_start)
        begin
            divisor_reg <= 32'(tlen_prod >> sbhs_pkg::DIV_SHIFT);
        end
        if (cmd.hash)
        begin
            bkt_reg <= (idx32 > sbhs_pkg::BUCKET_LAST) ? BW'(sbhs_pkg::BUCKET_LAST)
                                                       : idx32[BW-1:0];
        end
        if (cmd.fill_cap)
        begin
            fill_reg <= (fill_rd > FW'(sbhs_pkg::SLOTS)) ? FW'(sbhs_pkg::SLOTS) : fill_rd;
            pos_reg <= (fill_rd > FW'(sbhs_pkg::SLOTS)) ? FW'(sbhs_pkg::SLOTS) : fill_rd;
            idx_reg <= '0;
            stat_reg <= item_reg.action ? sbhs_pkg::ST_INSERTED : sbhs_pkg::ST_MISS;
            fv_reg <= '0;
        end
        if (cmd.scan_chk)
        begin
            if (key_rd == item_reg.key)
            begin
                stat_reg <= item_reg.action ? sbhs_pkg::ST_DUP : sbhs_pkg::ST_FOUND;
                fv_reg <= item_reg.action ? 32'd0 : val_rd;
            end
            else if (key_rd > item_reg.key)
            begin
                pos_reg <= idx_reg;
                idx_reg <= fill_reg;
            end
            else
            begin
                idx_reg <= idx_reg + FW'(1);
            end
        end
        if (cmd.shift_wr)
        begin
            idx_reg <= idx_reg - FW'(1);
        end
        if (cmd.out_load)
        begin
            out_reg.status <= (sts.full && stat_reg == sbhs_pkg::ST_INSERTED)
                ? sbhs_pkg::ST_FULL : stat_reg;
            out_reg.found_value <= fv_reg;
        end
    end

    assign sts.clr_done = clr_reg[BW];
    assign sts.div_busy = div_busy;
    assign sts.scan_end = (idx_reg >= fill_reg);
    assign sts.hit = (key_rd == item_reg.key);
    assign sts.larger = (key_rd > item_reg.key);
    assign sts.shift_done = (idx_reg <= pos_reg);
    assign sts.full = (fill_reg >= FW'(sbhs_pkg::SLOTS));
    assign sts.is_insert = item_reg.action;
    assign out_item = out_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> (fill_reg < FW'(sbhs_pkg::SLOTS)))
        else $error("insert into full bucket");
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_rd |-> (idx_reg > pos_reg))
        else $error("shift below insert point");
    a_place_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> (idx_reg == pos_reg))
        else $error("place before shift done");
`endif
endmodule
`default_nettype wire

### sim/tb.sv
// Testbench for the sorted bucket hash set: directed and random items checked against a predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sbhs_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sbhs_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;

    sorted_bucket_hash_set dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [31:0] text_len;
    logic [sbhs_pkg::FILL_W-1:0] fill_of [sbhs_pkg::BUCKETS];
    logic [31:0] keys_at [int];
    logic [31:0] vals_at [int];
    sbhs_pkg::out_item_t expected_q [$];

    int mismatches = 0;
    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int matched = 0;
    int inserted_keys [$];

    function automatic logic [31:0] bucket_for(logic [31:0] k);
        logic [31:0] idx;
        logic [31:0] dv;
        if (text_len < 32'(sbhs_pkg::BUCKETS))
            idx = k;
        else
        begin
            dv = text_len / 32'(sbhs_pkg::BUCKETS - 1);
            if (dv == 0)
                dv = 1;
            idx = k / dv;
        end
        if (idx > sbhs_pkg::BUCKET_LAST)
            idx = sbhs_pkg::BUCKET_LAST;
        return idx;
    endfunction

    function automatic sbhs_pkg::out_item_t predict_set(sbhs_pkg::in_item_t it);
        sbhs_pkg::out_item_t r;
        int b;
        int base;
        int f;
        int pos;
        int i;
        logic dup;
        b = int'(bucket_for(it.key));
        base = b * sbhs_pkg::SLOTS;
        f = int'(fill_of[b]);
        r.status = sbhs_pkg::ST_MISS;
        r.found_value = '0;
        pos = f;
        dup = 1'b0;
        for (i = 0; i < f; i++)
        begin
            if (keys_at[base + i] == it.key)
            begin
                dup = 1'b1;
                if (it.action == sbhs_pkg::ACT_LOOKUP)
                begin
                    r.status = sbhs_pkg::ST_FOUND;
                    r.found_value = vals_at[base + i];
                end
                break;
            end
            if (keys_at[base + i] > it.key)
            begin
                pos = i;
                break;
            end
        end
        if (it.action == sbhs_pkg::ACT_INSERT)
        begin
            if (dup)
                r.status = sbhs_pkg::ST_DUP;
            else if (f >= sbhs_pkg::SLOTS)
                r.status = sbhs_pkg::ST_FULL;
            else
            begin
                for (i = f; i > pos; i--)
                begin
                    keys_at[base + i] = keys_at[base + i - 1];
                    vals_at[base + i] = vals_at[base + i - 1];
                end
                keys_at[base + pos] = it.key;
                vals_at[base + pos] = it.value;
                fill_of[b] = sbhs_pkg::FILL_W'(f + 1);
                r.status = sbhs_pkg::ST_INSERTED;
                inserted_keys.push_back(it.key);
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall and result check
    always @(posedge clk)
    begin
        sbhs_pkg::out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected result status=%0d value=%h",
                             out_data.status, out_data.found_value);
                mismatches++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.status !== out_data.status || e.found_value !== out_data.found_value)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: exp status=%0d value=%h got status=%0d value=%h",
                                 e.status, e.found_value, out_data.status,
                                 out_data.found_value);
                    mismatches++;
                end
                else
                    matched++;
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(logic act, logic [31:0] k, logic [31:0] v);
        sbhs_pkg::in_item_t it;
        it.action = act;
        it.key = k;
        it.value = v;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(predict_set(it));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_length(logic [31:0] len);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        text_len = len;
    endtask

    // directed: extremes, full bucket, duplicates, ordering
    task automatic test_directed();
        int i;
        send_item(sbhs_pkg::ACT_LOOKUP, 32'd5, 32'd0);
        send_item(sbhs_pkg::ACT_INSERT, 32'd5, 32'hFFFFFFFF);
        send_item(sbhs_pkg::ACT_LOOKUP, 32'd5, 32'd0);
        send_item(sbhs_pkg::ACT_INSERT, 32'd5, 32'd1);
        // keys beyond the last bucket all land in it: fill, order, overflow
        for (i = 0; i < 9; i++)
            send_item(sbhs_pkg::ACT_INSERT, 32'hFFFFFFFF - 32'(i * 3),
                      32'(i) ^ 32'hA5A5A5A5);
        send_item(sbhs_pkg::ACT_INSERT, 32'hFFFFFFFF, 32'd7);
        send_item(sbhs_pkg::ACT_LOOKUP, 32'hFFFFFFF1, 32'd0);
        send_item(sbhs_pkg::ACT_LOOKUP, 32'hFFFFFFF0, 32'd0);
        send_item(sbhs_pkg::ACT_LOOKUP, 32'h00003FFF, 32'd0);
        send_item(sbhs_pkg::ACT_INSERT, 32'h0, 32'h0);
        send_item(sbhs_pkg::ACT_LOOKUP, 32'h0, 32'hFFFFFFFF);
    endtask

    task automatic test_random(int n, int spread);
        int i;
        logic [31:0] k;
        for (i = 0; i < n; i++)
        begin
            if (inserted_keys.size() != 0 && $urandom_range(2) == 0)
                k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
            else if ($urandom_range(3) == 0)
                k = $urandom();
            else
                k = 32'($urandom_range(spread));
            send_item(logic'($urandom_range(1)), k, $urandom());
        end
    endtask

    task automatic test_config_sweep();
        write_length(32'd0);
        test_random(150, 40);
        write_length(32'hFFFFFFFF);
        test_random(150, 32'h0FFFFFFF);
        write_length(32'd16384);
        test_random(150, 60);
        write_length(32'd1000000);
        test_random(150, 5000);
    endtask

    initial
    begin
        int i;
        text_len = 32'd1;
        for (i = 0; i < sbhs_pkg::BUCKETS; i++)
            fill_of[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 13;
        recv_idle = 62;
        test_directed();
        test_random(300, 30);
        // hold off until everything is back
        drain();
        send_idle = 62;
        recv_idle = 13;
        test_config_sweep();
        send_idle = 0;
        recv_idle = 0;
        write_length(32'd16383);
        test_random(330, 20000);
        drain();
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
